>>> rtl/vrm_pkg.sv
// ----------------------------------------------------------------------------
// vrm_pkg: shared types and constants for the voxel ray march block
// Grid geometry, cell word layout, fixed-point limits and the exp(-tau) table.
// ----------------------------------------------------------------------------
`default_nettype none

package vrm_pkg;

  localparam int GRID_DIM       = 32;
  localparam int EXP_TABLE_BITS = 10;

  localparam int NCELLS   = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int ADDR_W   = $clog2(NCELLS);
  localparam int CB       = $clog2(GRID_DIM);
  localparam int CW       = ((CB > 5) ? CB : 5) + 2;
  localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;

  // divider geometry
  localparam int DIVD_W = 36;
  localparam int DIVS_W = 16;

  localparam logic [47:0] T_INF    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] TAU_CAP  = 32'hFFFF_FFFF;
  localparam logic [39:0] SUM_MAX  = 40'hFF_FFFF_FFFF;
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] RATIO_X  = 16'd4096;

  // operation codes
  localparam logic [1:0] OP_LOAD_FLOW = 2'd0;
  localparam logic [1:0] OP_LOAD_WALL = 2'd1;
  localparam logic [1:0] OP_TRACE     = 2'd2;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REFLECT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_SIZE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_Y_RATIO   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_Z_RATIO   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MAX_REFL  = 3'd5;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [16:0]          exp_val_t;
  typedef exp_val_t             exp_tab_t [EXP_SIZE];

  typedef struct packed {
    logic        flow;
    logic [31:0] emission;
    logic [23:0] absorption;
  } cell_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t     tab;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  e;
    logic [63:0]  a;
    logic [127:0] prod;
    term = 64'd1 << 62;
    sum  = 64'd1 << 62;
    for (int n = 1; n <= 24; n++) begin
      term = (term >> (EXP_TABLE_BITS - 4)) / 64'(n);
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    e = (sum + (64'd1 << 29)) >> 30;
    a = 64'd1 << 32;
    for (int i = 0; i < EXP_SIZE; i++) begin
      tab[i] = 17'((a + 64'd32768) >> 16);
      prod   = 128'(a) * 128'(e) + (128'd1 << 31);
      a      = 64'(prod >> 32);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  function automatic exp_val_t exp_lookup(input logic [31:0] tau);
    logic [31:0] idx;
    idx = tau >> (20 - EXP_TABLE_BITS);
    if (idx >= 32'(EXP_SIZE)) return '0;
    return EXP_TAB[idx[EXP_TABLE_BITS-1:0]];
  endfunction

  function automatic logic in_grid(input coord_t x, input coord_t y, input coord_t z);
    return (x >= 0) && (x < coord_t'(GRID_DIM)) &&
           (y >= 0) && (y < coord_t'(GRID_DIM)) &&
           (z >= 0) && (z < coord_t'(GRID_DIM));
  endfunction

  function automatic addr_t cell_addr(input coord_t x, input coord_t y, input coord_t z);
    addr_t ux;
    addr_t uy;
    addr_t uz;
    ux = ADDR_W'(unsigned'(x));
    uy = ADDR_W'(unsigned'(y));
    uz = ADDR_W'(unsigned'(z));
    return (uz * addr_t'(GRID_DIM) + uy) * addr_t'(GRID_DIM) + ux;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vrm_ram.sv
// ----------------------------------------------------------------------------
// vrm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/vrm_div.sv
// ----------------------------------------------------------------------------
// vrm_div: restoring divider, one quotient bit per cycle
// Unsigned DIVD_W by DIVS_W bit division; busy drops when quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vrm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [vrm_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [vrm_pkg::DIVS_W-1:0]  divisor,
  output logic                             busy,
  output logic      [vrm_pkg::DIVD_W-1:0]  quotient
);

  import vrm_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem, quotient[DIVD_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVD_W-2:0], fits};
      rem      <= fits ? DIVS_W'(trial - {1'b0, dvs}) : trial[DIVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/voxel_ray_march_radiance.sv
// ----------------------------------------------------------------------------
// voxel_ray_march_radiance: 3D DDA ray march with radiance gathering
// Cells are loaded into a grid RAM; a trace beat marches a ray cell by cell,
// accumulating optical thickness and emitted radiance, reflecting off walls.
// ----------------------------------------------------------------------------
// Load beats give no result.
// A trace runs a setup per nonzero direction axis (one multiply and two serial
// divisions), then an origin read, the step states for each cell crossed, the wall
// states for each wall hit, a mirror state per reflection and the output register. One trace is
// in flight at a time; the serial divider sets the setup time, the multiplier the step.
// After reset the flow flags of all 32768 cells are cleared; no beat is taken then.
`default_nettype none

module voxel_ray_march_radiance (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // cell_x[4:0] cell_y[9:5] cell_z[14:10] absorption[38:15] emission[70:39]
  // dir_x[86:71] dir_y[102:87] dir_z[118:103] off_x[134:119] off_y[150:135]
  // off_z[166:151], zero pad [167]
  input  wire logic [167:0]                 s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]                   s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // radiance_sum[39:0] step_count[55:40] reflection_count[63:56]
  // reflect_capped[64], zero pad [71:65]
  output logic      [71:0]                  m_axis_tdata,
  // configuration write port
  input  wire logic                         cfg_we,
  input  wire logic [vrm_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [23:0]                  cfg_wdata
);

  import vrm_pkg::*;

  typedef enum logic [17:0] {
    ST_CLEAR = 18'h00001,
    ST_IDLE  = 18'h00002,
    ST_SET0  = 18'h00004,
    ST_SET1  = 18'h00008,
    ST_SET2  = 18'h00010,
    ST_ORG   = 18'h00020,
    ST_STEP  = 18'h00040,
    ST_CA    = 18'h00080,
    ST_TAU   = 18'h00100,
    ST_EXP   = 18'h00200,
    ST_VOL   = 18'h00400,
    ST_VADD  = 18'h00800,
    ST_W1    = 18'h01000,
    ST_W2    = 18'h02000,
    ST_W3    = 18'h04000,
    ST_W4    = 18'h08000,
    ST_W5    = 18'h10000,
    ST_DONE  = 18'h20000
  } state_t;

  state_t state;
  addr_t  clr_addr;

  // configuration registers
  logic [15:0] thr;
  logic        allow_refl;
  logic [23:0] cell_size;
  logic [15:0] y_ratio;
  logic [15:0] z_ratio;
  logic [7:0]  max_refl;

  // unpacked input beat
  logic [1:0]  in_op;
  logic [4:0]  in_x;
  logic [4:0]  in_y;
  logic [4:0]  in_z;
  logic [23:0] in_abs;
  logic [31:0] in_emis;
  logic        in_acc;
  logic        load_ok;

  // ray state
  logic signed [15:0] dir [3];
  logic [15:0]        off [3];
  coord_t             c [3];
  coord_t             p [3];
  logic [2:0]         neg;
  logic [1:0]         dsel;
  logic [1:0]         face;
  logic [47:0]        tmax [3];
  logic [DIVD_W-1:0]  tdel [3];
  logic [47:0]        tprev;
  logic [47:0]        seg_len;
  logic               ca_nz;
  logic [31:0]        tau;
  logic [39:0]        sum;
  exp_val_t           eprev;
  exp_val_t           fs;
  exp_val_t           eps;
  logic [15:0]        steps;
  logic [7:0]         refl;
  logic               capped;
  cell_t              cw;
  cell_t              nw;

  // shared multiplier
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] mres;

  // grid RAM
  logic  ram_we;
  addr_t ram_waddr;
  cell_t ram_wdata;
  addr_t ram_raddr;
  cell_t ram_rdata;
  logic  c_in_grid;

  // divider
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic              div_busy;
  logic [DIVD_W-1:0] div_quo;

  // setup helpers for the axis under dsel
  logic signed [15:0] dir_d;
  logic [15:0]        off_d;
  logic [15:0]        ratio_d;
  logic [15:0]        mag_d;
  logic [16:0]        frac_d;

  // step helpers
  logic [1:0]  fsel;
  logic [48:0] tsum;
  exp_val_t    ecur;
  exp_val_t    diff;
  exp_val_t    eps_c;
  logic [47:0] inc;
  logic [48:0] tau_sum;
  logic [31:0] tau_sat;
  logic [40:0] sum_add;
  logic [39:0] sum_sat;
  exp_val_t    inten;

  // output register
  logic [39:0] o_sum;
  logic [15:0] o_steps;
  logic [7:0]  o_refl;
  logic        o_cap;
  logic        out_load;

  assign in_op   = s_axis_tuser;
  assign in_x    = s_axis_tdata[4:0];
  assign in_y    = s_axis_tdata[9:5];
  assign in_z    = s_axis_tdata[14:10];
  assign in_abs  = s_axis_tdata[38:15];
  assign in_emis = s_axis_tdata[70:39];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = in_grid(coord_t'(CW'(in_x)), coord_t'(CW'(in_y)),
                                 coord_t'(CW'(in_z)));

  assign m_axis_tdata = {7'b0, o_cap, o_refl, o_steps, o_sum};

  // grid RAM: write from the clear sweep or a load beat, read the current cell
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_acc && (in_op == OP_LOAD_FLOW || in_op == OP_LOAD_WALL) && load_ok) begin
      ram_we              = 1'b1;
      ram_waddr           = cell_addr(coord_t'(CW'(in_x)), coord_t'(CW'(in_y)),
                                      coord_t'(CW'(in_z)));
      ram_wdata.flow       = (in_op == OP_LOAD_FLOW);
      ram_wdata.emission   = in_emis;
      ram_wdata.absorption = in_abs;
    end
  end

  assign ram_raddr = cell_addr(c[0], c[1], c[2]);
  assign c_in_grid = in_grid(c[0], c[1], c[2]);

  vrm_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (NCELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // setup view of one axis
  always_comb begin
    case (dsel)
      2'd0: begin
        dir_d   = dir[0];
        off_d   = off[0];
        ratio_d = RATIO_X;
      end
      2'd1: begin
        dir_d   = dir[1];
        off_d   = off[1];
        ratio_d = y_ratio;
      end
      default: begin
        dir_d   = dir[2];
        off_d   = off[2];
        ratio_d = z_ratio;
      end
    endcase
    mag_d  = dir_d[15] ? 16'(-dir_d) : 16'(dir_d);
    frac_d = (dir_d > 0) ? ONE_Q16 - 17'(off_d) : 17'(off_d);
  end

  // divider requests: crossing length, then first crossing distance
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVD_W'(ratio_d) << 19;
    if (state == ST_SET0 && mag_d != '0) begin
      div_start = 1'b1;
    end else if (state == ST_SET1 && !div_busy) begin
      div_start    = 1'b1;
      div_dividend = DIVD_W'(mres[31:0]) << 3;
    end
  end

  vrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (mag_d),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // nearest face: x only if strictly below both, then y if strictly below z
  always_comb begin
    if (tmax[0] < tmax[1]) fsel = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else                   fsel = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
    tsum = 49'(tmax[fsel]) + 49'(tdel[fsel]);
  end

  always_comb begin
    ecur  = exp_lookup(tau);
    diff  = (eprev > ecur) ? eprev - ecur : '0;
    eps_c = (nw.absorption > 24'(ONE_Q16)) ? ONE_Q16 : 17'(nw.absorption);
    if (seg_len[47:32] != '0) inc = ca_nz ? 48'(TAU_CAP) : '0;
    else                      inc = mres[63:16];
    tau_sum = 49'(tau) + 49'(inc);
    tau_sat = (tau_sum > 49'(TAU_CAP)) ? TAU_CAP : tau_sum[31:0];
    sum_add = 41'(sum) + 41'(mres[65:32]);
    sum_sat = (sum_add > 41'(SUM_MAX)) ? SUM_MAX : sum_add[39:0];
    inten   = mres[32:16];
  end

  // shared multiplier operands, one product per cycle, always registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SET0, ST_SET1: begin
        // hold frac * ratio until the second division starts
        mul_a = 34'(frac_d);
        mul_b = 32'(ratio_d);
      end
      ST_STEP: begin
        mul_a = 34'(cw.absorption);
        mul_b = 32'(cell_size);
      end
      ST_CA: begin
        mul_a = 34'(mres[47:16]);
        mul_b = seg_len[31:0];
      end
      ST_EXP: begin
        mul_a = 34'(diff);
        mul_b = 32'(fs);
      end
      ST_VOL: begin
        mul_a = mres[33:0];
        mul_b = cw.emission;
      end
      ST_W1: begin
        mul_a = 34'(eps_c);
        mul_b = 32'(eprev);
      end
      ST_W2: begin
        mul_a = mres[33:0];
        mul_b = nw.emission;
      end
      ST_W3: begin
        mul_a = 34'(eprev);
        mul_b = 32'(fs);
      end
      ST_W4: begin
        mul_a = 34'(fs);
        mul_b = 32'(ONE_Q16 - eps);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mres <= 66'(mul_a) * 66'(mul_b);
  end

  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= 16'd655;
      allow_refl <= 1'b0;
      cell_size  <= 24'd65536;
      y_ratio    <= 16'd4096;
      z_ratio    <= 16'd4096;
      max_refl   <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD: thr        <= cfg_wdata[15:0];
        REG_REFLECT:   allow_refl <= cfg_wdata[0];
        REG_CELL_SIZE: cell_size  <= cfg_wdata;
        REG_Y_RATIO:   y_ratio    <= cfg_wdata[15:0];
        REG_Z_RATIO:   z_ratio    <= cfg_wdata[15:0];
        REG_MAX_REFL:  max_refl   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_sum   <= sum;
      o_steps <= steps;
      o_refl  <= refl;
      o_cap   <= capped;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == addr_t'(NCELLS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc && in_op == OP_TRACE) state <= ST_SET0;
        end
        ST_SET0: begin
          if (mag_d != '0)        state <= ST_SET1;
          else if (dsel == 2'd2)  state <= ST_ORG;
        end
        ST_SET1: if (!div_busy) state <= ST_SET2;
        ST_SET2: begin
          if (!div_busy) state <= (dsel == 2'd2) ? ST_ORG : ST_SET0;
        end
        ST_ORG:  state <= ST_STEP;
        ST_STEP: state <= ST_CA;
        ST_CA:   state <= ST_TAU;
        ST_TAU:  state <= ST_EXP;
        ST_EXP:  state <= ST_VOL;
        ST_VOL:  state <= ST_VADD;
        ST_VADD: state <= nw.flow ? ST_STEP : ST_W1;
        ST_W1:   state <= ST_W2;
        ST_W2:   state <= ST_W3;
        ST_W3:   state <= ST_W4;
        ST_W4: begin
          if (!allow_refl || inten <= 17'(thr) || refl >= max_refl) state <= ST_DONE;
          else                                                     state <= ST_W5;
        end
        ST_W5:   state <= ST_STEP;
        ST_DONE: if (out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ray datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // latch the trace beat and clear the accumulators
        dir[0] <= s_axis_tdata[86:71];
        dir[1] <= s_axis_tdata[102:87];
        dir[2] <= s_axis_tdata[118:103];
        off[0] <= s_axis_tdata[134:119];
        off[1] <= s_axis_tdata[150:135];
        off[2] <= s_axis_tdata[166:151];
        c[0]   <= coord_t'(CW'(in_x));
        c[1]   <= coord_t'(CW'(in_y));
        c[2]   <= coord_t'(CW'(in_z));
        dsel   <= 2'd0;
        tprev  <= '0;
        tau    <= '0;
        sum    <= '0;
        eprev  <= ONE_Q16;
        fs     <= ONE_Q16;
        steps  <= '0;
        refl   <= '0;
        capped <= 1'b0;
      end
      ST_SET0: begin
        neg[dsel] <= dir_d[15];
        if (mag_d == '0) begin
          // zero component never crosses a face
          tmax[dsel] <= T_INF;
          tdel[dsel] <= '0;
          if (dsel != 2'd2) dsel <= dsel + 1'b1;
        end
      end
      ST_SET1: if (!div_busy) tdel[dsel] <= div_quo;
      ST_SET2: begin
        if (!div_busy) begin
          tmax[dsel] <= 48'(div_quo);
          if (dsel != 2'd2) dsel <= dsel + 1'b1;
        end
      end
      ST_ORG: cw <= c_in_grid ? ram_rdata : '0;
      ST_STEP: begin
        // cross the nearest face
        p[0]       <= c[0];
        p[1]       <= c[1];
        p[2]       <= c[2];
        face       <= fsel;
        c[fsel]    <= neg[fsel] ? c[fsel] - coord_t'(1) : c[fsel] + coord_t'(1);
        seg_len    <= tmax[fsel] - tprev;
        tprev      <= tmax[fsel];
        tmax[fsel] <= (tsum > 49'(T_INF)) ? T_INF : tsum[47:0];
        if (steps != 16'hFFFF) steps <= steps + 1'b1;
      end
      ST_CA:  ca_nz <= (mres[47:16] != '0);
      ST_TAU: begin
        tau <= tau_sat;
        nw  <= c_in_grid ? ram_rdata : '0;
      end
      ST_EXP: eprev <= ecur;
      ST_VADD: begin
        sum <= sum_sat;
        if (nw.flow) cw <= nw;
      end
      ST_W1: eps <= eps_c;
      ST_W3: sum <= sum_sat;
      ST_W4: begin
        if (allow_refl && inten > 17'(thr) && refl >= max_refl) capped <= 1'b1;
      end
      ST_W5: begin
        // mirror back into the previous cell, weaker by the wall's emissivity
        fs        <= mres[32:16];
        c[0]      <= p[0];
        c[1]      <= p[1];
        c[2]      <= p[2];
        neg[face] <= !neg[face];
        refl      <= refl + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
